// ===== src/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SYM_W       = 8;

    // Character codes
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_DIG0   = 8'h30;
    localparam logic [SYM_W-1:0] CH_DIG9   = 8'h39;
    localparam logic [SYM_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [SYM_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [SYM_W-1:0] CH_UP_Z   = 8'h5A;

    // Bit positions inside the result tuser
    localparam int USER_W        = 3;
    localparam int USER_SYM_VLD  = 0;
    localparam int USER_EXPR_END = 1;
    localparam int USER_OVF      = 2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Priority offset by one so it stays unsigned: unknown 0, '(' 1, +- 2, */ 3, ^ 4
    function automatic logic [2:0] rank(input logic [SYM_W-1:0] c);
        logic [2:0] r;
        case (c)
            CH_PLUS, CH_MINUS: r = 3'd2;
            CH_STAR, CH_SLASH: r = 3'd3;
            CH_CARET:          r = 3'd4;
            CH_LPAREN:         r = 3'd1;
            default:           r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_operand(input logic [SYM_W-1:0] c);
        return c inside {[CH_DIG0:CH_DIG9], [CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]};
    endfunction

endpackage

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata[7:0] symbol, tlast end_marker
// m_axis    out  m_axis_tvalid/tready    tdata[7:0] out_symbol, tlast last_of_run,
//                                        tuser[0] symbol_valid, [1] expr_done,
//                                        [2] overflow_seen
//
// One word at a time: s_axis_tready is high only in the idle state.
// An operand, '(' or any word that meets an empty stack goes from idle straight to the
// finish state; any other word first passes the compare, and every pop adds a stack read
// through the registered RAM port (the fetch state), then the compare.
// The last result of a word leaves through a one-deep holding register, so its tlast
// is known when it is handed to the output register; a full output register stalls.
// rst_n clears the stack count, the overflow flag and all valid flags; the stack RAM
// itself is not cleared and needs no clearing pass.

module infix_to_postfix_converter
    import itp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [SYM_W-1:0]  s_axis_tdata,   // [7:0] symbol
    input  logic              s_axis_tlast,   // end_marker
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [SYM_W-1:0]  m_axis_tdata,   // [7:0] out_symbol
    output logic [USER_W-1:0] m_axis_tuser,   // [0] symbol_valid, [1] expr_done,
                                              // [2] overflow_seen
    output logic              m_axis_tlast    // last_of_run
);

    state_t state_reg, state_next;

    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             end_reg, end_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    // Holding register for the most recent result of the current word
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             pend_ovf_reg, pend_ovf_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic [USER_W-1:0] out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    logic              in_accept;
    logic              out_free;
    logic [CNT_W-1:0]  count_dec;
    logic              stack_full;
    logic              stack_empty;
    logic [SYM_W-1:0]  top_sym;
    logic              pop_cond;
    logic              need_out;
    logic              finish_go;
    logic              do_push;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ADDR_W-1:0] ram_rd_addr;

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign count_dec   = count_reg - CNT_W'(1);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);

    // Keep the top entry on the read port at all times; it is valid in the cycle
    // after the count settles.
    assign ram_rd_addr = count_dec[ADDR_W-1:0];
    assign ram_wr_addr = count_reg[ADDR_W-1:0];

    itp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (sym_reg),
        .rd_addr (ram_rd_addr),
        .rd_data (top_sym)
    );

    // Pop while the top entry qualifies for this word
    always_comb
    begin
        pop_cond = 1'b0;
        if (!stack_empty)
        begin
            if (end_reg)
            begin
                pop_cond = 1'b1;
            end
            else if (sym_reg == CH_RPAREN)
            begin
                pop_cond = (top_sym != CH_LPAREN);
            end
            else
            begin
                pop_cond = (rank(sym_reg) <= rank(top_sym));
            end
        end
    end

    assign need_out  = pend_valid_reg || end_reg;
    assign finish_go = !need_out || out_free;
    assign do_push   = !end_reg && !is_operand(sym_reg) && (sym_reg != CH_RPAREN);
    assign ram_wr_en = (state_reg == ST_FINISH) && finish_go && do_push && !stack_full;

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        end_next        = end_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_sym_next    = out_sym_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sym_next = s_axis_tdata;
                    end_next = s_axis_tlast;
                    if (s_axis_tlast)
                    begin
                        state_next = stack_empty ? ST_FINISH : ST_DECIDE;
                    end
                    else if (is_operand(s_axis_tdata))
                    begin
                        // Operand: pass straight through
                        pend_valid_next = 1'b1;
                        pend_sym_next   = s_axis_tdata;
                        pend_ovf_next   = ovf_reg;
                        state_next      = ST_FINISH;
                    end
                    else if (s_axis_tdata == CH_LPAREN || stack_empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (pop_cond)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        // Older result is not the last one: release it without tlast
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_user_next  = '0;
                            out_user_next[USER_SYM_VLD] = 1'b1;
                            out_user_next[USER_OVF]     = pend_ovf_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = top_sym;
                        pend_ovf_next   = ovf_reg;
                        count_next      = count_dec;
                        state_next      = ST_FETCH;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FETCH:
            begin
                // Wait for the new top entry on the read port
                state_next = ST_DECIDE;
            end

            ST_FINISH:
            begin
                if (finish_go)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_sym_next   = pend_sym_reg;
                        out_user_next  = '0;
                        out_user_next[USER_SYM_VLD]  = 1'b1;
                        out_user_next[USER_EXPR_END] = end_reg;
                        out_user_next[USER_OVF]      = pend_ovf_reg;
                        out_last_next  = 1'b1;
                    end
                    else if (end_reg)
                    begin
                        // End marker with nothing left to pop: one word with no character
                        out_valid_next = 1'b1;
                        out_sym_next   = '0;
                        out_user_next  = '0;
                        out_user_next[USER_EXPR_END] = 1'b1;
                        out_user_next[USER_OVF]      = ovf_reg;
                        out_last_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;

                    if (do_push)
                    begin
                        if (stack_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (!end_reg && sym_reg == CH_RPAREN && !stack_empty)
                    begin
                        // Drop the matching '('
                        count_next = count_dec;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        end_reg      <= end_next;
        pend_sym_reg <= pend_sym_next;
        pend_ovf_reg <= pend_ovf_next;
        out_sym_reg  <= out_sym_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== src/itp_ram.sv =====
`timescale 1ns / 1ps

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
